// ===== hw/rtl/sha1_byte_stream_hasher_core_macros.svh =====
// assertion macros shared by the sha-1 byte stream hasher rtl
// no dependencies; pulled in by files that carry concurrent assertions
`ifndef SHA1_BYTE_STREAM_HASHER_CORE_MACROS_SVH
`define SHA1_BYTE_STREAM_HASHER_CORE_MACROS_SVH

// condition holds on every clock edge out of reset
`define SHA1BS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define SHA1BS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SHA1BS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sha1bs_pkg.sv =====
// types and constants for the sha-1 byte stream hasher
// no dependencies; used by sha1bs_round and sha1_byte_stream_hasher_core
package sha1bs_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } seq_state_t;

    // five 32-bit words: working variables a..e or chaining values h0..h4
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } round_vars_t;

    // initial chaining values
    localparam round_vars_t IV_VARS = '{
        a: 32'h67452301,
        b: 32'hEFCDAB89,
        c: 32'h98BADCFE,
        d: 32'h10325476,
        e: 32'hC3D2E1F0
    };

    // round constants
    localparam logic [31:0] K_RND0 = 32'h5A827999;
    localparam logic [31:0] K_RND1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_RND2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_RND3 = 32'hCA62C1D6;

    // round group boundaries and last round
    localparam logic [6:0] RND_GRP1   = 7'd20;
    localparam logic [6:0] RND_GRP2   = 7'd40;
    localparam logic [6:0] RND_GRP3   = 7'd60;
    localparam logic [6:0] RND_LAST   = 7'd79;

    // padding
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;

    // digest words
    localparam logic [2:0] WORD_LAST  = 3'd4;

endpackage

// ===== hw/rtl/sha1_byte_stream_hasher_core.sv =====
// sha-1 byte stream hasher top level: byte packing, padding, round sequencer
// depends on sha1bs_pkg, sha1bs_round and sha1_byte_stream_hasher_core_macros.svh
//
// Message bytes enter at most one per item (has_byte in tuser) and are
// shifted into a 512-bit block register that doubles as the 16-word rolling
// message schedule. Items are taken only while the sequencer is idle. The
// item that completes a 64-byte block starts a compression on the single
// shared round unit, one round per cycle: 80 rounds, then one chaining
// update, while the input is not ready. An end item (tlast) starts padding,
// written one byte per cycle (0x80, zeros up to byte 56, where the sequencer
// moves to the length state without writing, then the eight length bytes),
// followed by one compression, or two when the 0x80 lands at byte 56 or later.
// The five digest words h0..h4 then leave on the output, index in tuser,
// tlast on h4, after which the chaining values and counters return to their
// initial state.
`include "sha1_byte_stream_hasher_core_macros.svh"

module sha1_byte_stream_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);
    import sha1bs_pkg::*;

    seq_state_t  state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [60:0] count_reg, count_next;
    logic        fin_reg, fin_next;
    logic        len_done_reg, len_done_next;
    logic        pad_one_reg, pad_one_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;
    round_vars_t chain_reg, chain_next;
    round_vars_t vars_reg, vars_next;
    logic [511:0] blk_reg, blk_next;

    logic        accept_in;
    logic        accept_out;
    logic        pad_to_len;
    logic [63:0] len_bits;
    logic [2:0]  len_sel;
    logic [7:0]  len_byte;
    logic [31:0] sched_xor;
    logic [31:0] sched_new;
    round_vars_t round_out;

    // shared round unit
    sha1bs_round u_round (
        .vars_in  (vars_reg),
        .w        (blk_reg[511:480]),
        .rnd      (rnd_reg),
        .vars_out (round_out)
    );

    // handshakes and small decodes
    assign accept_in  = s_axis_tvalid && s_axis_tready;
    assign accept_out = m_axis_tvalid && m_axis_tready;
    assign pad_to_len = !pad_one_reg && (pos_reg == LEN_POS);

    // length byte for the current position, most significant first
    assign len_bits = {count_reg, 3'b000};
    assign len_sel  = 3'd7 - pos_reg[2:0];
    assign len_byte = len_bits[{len_sel, 3'b000} +: 8];

    // schedule expansion from words 13, 8, 2 and 0 of the window
    assign sched_xor = blk_reg[95:64] ^ blk_reg[255:224] ^ blk_reg[447:416] ^
                       blk_reg[511:480];
    assign sched_new = {sched_xor[30:0], sched_xor[31]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    if (s_axis_tuser && (pos_reg == LAST_POS))
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                if (rnd_reg == RND_LAST)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_done_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (pad_to_len)
                begin
                    state_next = ST_LEN;
                end
                else if (pos_reg == LAST_POS)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_LEN:
            begin
                if (pos_reg == LAST_POS)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_OUT:
            begin
                if (accept_out && (idx_reg == WORD_LAST))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // port outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        m_axis_tvalid = (state_reg == ST_OUT);
        m_axis_tdata  = chain_reg.a;
        m_axis_tuser  = idx_reg;
        m_axis_tlast  = (idx_reg == WORD_LAST);
    end

    // datapath and counters
    always_comb
    begin
        pos_next      = pos_reg;
        count_next    = count_reg;
        fin_next      = fin_reg;
        len_done_next = len_done_reg;
        pad_one_next  = pad_one_reg;
        rnd_next      = rnd_reg;
        idx_next      = idx_reg;
        chain_next    = chain_reg;
        vars_next     = vars_reg;
        blk_next      = blk_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    if (s_axis_tuser)
                    begin
                        blk_next   = {blk_reg[503:0], s_axis_tdata};
                        pos_next   = pos_reg + 6'd1;
                        count_next = count_reg + 61'd1;
                    end
                    if (s_axis_tlast)
                    begin
                        fin_next      = 1'b1;
                        pad_one_next  = 1'b1;
                        len_done_next = 1'b0;
                    end
                end
            end
            ST_ROUND:
            begin
                blk_next  = {blk_reg[479:0], sched_new};
                vars_next = round_out;
                rnd_next  = rnd_reg + 7'd1;
            end
            ST_UPDATE:
            begin
                chain_next.a = chain_reg.a + vars_reg.a;
                chain_next.b = chain_reg.b + vars_reg.b;
                chain_next.c = chain_reg.c + vars_reg.c;
                chain_next.d = chain_reg.d + vars_reg.d;
                chain_next.e = chain_reg.e + vars_reg.e;
            end
            ST_PAD:
            begin
                if (!pad_to_len)
                begin
                    blk_next     = {blk_reg[503:0], (pad_one_reg ? PAD_BYTE : 8'h00)};
                    pos_next     = pos_reg + 6'd1;
                    pad_one_next = 1'b0;
                end
            end
            ST_LEN:
            begin
                blk_next = {blk_reg[503:0], len_byte};
                pos_next = pos_reg + 6'd1;
                if (pos_reg == LAST_POS)
                begin
                    len_done_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (accept_out)
                begin
                    if (idx_reg == WORD_LAST)
                    begin
                        chain_next    = IV_VARS;
                        idx_next      = 3'd0;
                        count_next    = '0;
                        pos_next      = '0;
                        fin_next      = 1'b0;
                        len_done_next = 1'b0;
                    end
                    else
                    begin
                        chain_next = {chain_reg.b, chain_reg.c, chain_reg.d,
                                      chain_reg.e, chain_reg.e};
                        idx_next   = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase

        // compression start: load working variables from the chain
        if ((state_next == ST_ROUND) && (state_reg != ST_ROUND))
        begin
            vars_next = chain_reg;
            rnd_next  = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            count_reg    <= '0;
            fin_reg      <= 1'b0;
            len_done_reg <= 1'b0;
            pad_one_reg  <= 1'b0;
            rnd_reg      <= '0;
            idx_reg      <= '0;
            chain_reg    <= IV_VARS;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            count_reg    <= count_next;
            fin_reg      <= fin_next;
            len_done_reg <= len_done_next;
            pad_one_reg  <= pad_one_next;
            rnd_reg      <= rnd_next;
            idx_reg      <= idx_next;
            chain_reg    <= chain_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        vars_reg <= vars_next;
        blk_reg  <= blk_next;
    end

    // checks
    `SHA1BS_ASSERT_ALWAYS(a_sides_apart, clk, rst_n, !(s_axis_tready && m_axis_tvalid), "input ready while digest is out")
    `SHA1BS_ASSERT_IMP(a_round_range, clk, rst_n, state_reg == ST_ROUND, rnd_reg <= RND_LAST, "round counter past last round")
    `SHA1BS_ASSERT_IMP(a_out_pos, clk, rst_n, m_axis_tvalid, (pos_reg == 6'd0) && len_done_reg, "digest out before padding done")
    `SHA1BS_ASSERT_NEXT(a_chain_restart, clk, rst_n, accept_out && m_axis_tlast, (chain_reg == IV_VARS) && (count_reg == 61'd0), "chain not restored after digest")

endmodule

// ===== hw/rtl/sha1bs_round.sv =====
// one sha-1 round: boolean function, constant select and five-way add
// depends on sha1bs_pkg for round_vars_t and the round constants
module sha1bs_round (
    input  sha1bs_pkg::round_vars_t vars_in,
    input  logic [31:0]             w,
    input  logic [6:0]              rnd,
    output sha1bs_pkg::round_vars_t vars_out
);
    import sha1bs_pkg::*;

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] t;

    // function and constant by round group
    always_comb
    begin
        if (rnd < RND_GRP1)
        begin
            f = (vars_in.b & vars_in.c) | (~vars_in.b & vars_in.d);
            k = K_RND0;
        end
        else if (rnd < RND_GRP2)
        begin
            f = vars_in.b ^ vars_in.c ^ vars_in.d;
            k = K_RND1;
        end
        else if (rnd < RND_GRP3)
        begin
            f = (vars_in.b & vars_in.c) | (vars_in.b & vars_in.d) |
                (vars_in.c & vars_in.d);
            k = K_RND2;
        end
        else
        begin
            f = vars_in.b ^ vars_in.c ^ vars_in.d;
            k = K_RND3;
        end
    end

    // temp word and variable rotation
    always_comb
    begin
        t = {vars_in.a[26:0], vars_in.a[31:27]} + f + vars_in.e + k + w;
        vars_out.a = t;
        vars_out.b = vars_in.a;
        vars_out.c = {vars_in.b[1:0], vars_in.b[31:2]};
        vars_out.d = vars_in.c;
        vars_out.e = vars_in.d;
    end

endmodule
